// ===== design/itoa_pkg.sv =====
// Package for the integer to ASCII converter: kind codes, character codes,
// controller state type and the digit glyph lookup. No dependencies.
package itoa_pkg;

  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int DEC_BITS   = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int BITCNT_W   = $clog2(DEC_BITS);
  localparam int HEX_FULL   = 16;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOWA  = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = CHAR_ZERO + {4'd0, d};
    end else begin
      g = CHAR_LOWA + {4'd0, d - 4'd10};
    end
    return g;
  endfunction

endpackage

// ===== design/integer_to_ascii_digits_core.sv =====
// Integer to ASCII converter: bit-serial binary to BCD, leading zero strip and one
// character per unstalled cycle out of a digit shift register. Uses itoa_pkg.
//
//  channel | ports                               | direction
//  input   | in_valid in_ready in_kind in_value  | into the block
//  result  | out_valid out_ready out_character   | out of the block
//          | out_last                            |
//
// Decimal kinds load the operand, run shift-and-add-3 (one operand bit per
// cycle), strip leading zeros one per cycle, put out a minus sign if needed,
// then one character per cycle while out_ready allows. Hex skips the
// conversion.
// The output register holds a character while out_ready is low; the last
// character waits there while the next item is already being converted.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register. Unused kind codes are accepted and dropped.
module integer_to_ascii_digits_core #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last
);

  localparam int BUF_W      = MAX_DIGITS * 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int HEX_DIGITS = (MAX_DIGITS < itoa_pkg::HEX_FULL) ? MAX_DIGITS
                                                                 : itoa_pkg::HEX_FULL;
  localparam int HEX_W      = HEX_DIGITS * 4;

  itoa_pkg::state_t state_r, state_nxt;

  logic [itoa_pkg::DEC_BITS-1:0] sreg_r, sreg_nxt;
  logic [itoa_pkg::BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [itoa_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BUF_W-1:0]              buf_r, buf_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [itoa_pkg::BCD_W-1:0]    bcd_adj;
  logic [3:0]                    top_digit;
  logic                          slot_free;

  assign in_ready      = (state_r == itoa_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  assign top_digit = buf_r[BUF_W-1 -: 4];
  assign slot_free = !out_valid_r || out_ready;

  // add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sreg_r     <= sreg_nxt;
    bcd_r      <= bcd_nxt;
    buf_r      <= buf_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sreg_nxt      = sreg_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          neg_nxt     = 1'b0;
          unique case (in_kind)
            itoa_pkg::KIND_SDEC: begin
              if (in_value[31]) begin
                neg_nxt  = 1'b1;
                sreg_nxt = 32'd0 - in_value[31:0];
              end else begin
                sreg_nxt = in_value[31:0];
              end
              state_nxt = itoa_pkg::ST_CONV;
            end
            itoa_pkg::KIND_UDEC: begin
              sreg_nxt  = in_value[31:0];
              state_nxt = itoa_pkg::ST_CONV;
            end
            itoa_pkg::KIND_HEX: begin
              buf_nxt   = BUF_W'(in_value[HEX_W-1:0]) << ((MAX_DIGITS - HEX_DIGITS) * 4);
              cnt_nxt   = CNT_W'(HEX_DIGITS);
              // keep every held digit when higher digits overflow the buffer
              if ((in_value >> HEX_W) != 64'd0) begin
                state_nxt = itoa_pkg::ST_EMIT;
              end else begin
                state_nxt = itoa_pkg::ST_STRIP;
              end
            end
            default: begin
              // unused kind: drop the item
              state_nxt = itoa_pkg::ST_IDLE;
            end
          endcase
        end
      end

      itoa_pkg::ST_CONV: begin
        bcd_nxt     = {bcd_adj[itoa_pkg::BCD_W-2:0], sreg_r[itoa_pkg::DEC_BITS-1]};
        sreg_nxt    = {sreg_r[itoa_pkg::DEC_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == itoa_pkg::BITCNT_W'(itoa_pkg::DEC_BITS - 1)) begin
          buf_nxt   = BUF_W'({bcd_adj[itoa_pkg::BCD_W-2:0], sreg_r[itoa_pkg::DEC_BITS-1]})
                      << ((MAX_DIGITS - itoa_pkg::DEC_DIGITS) * 4);
          cnt_nxt   = CNT_W'(itoa_pkg::DEC_DIGITS);
          state_nxt = itoa_pkg::ST_STRIP;
        end
      end

      itoa_pkg::ST_STRIP: begin
        // drop leading zeros, keep at least one digit
        if (cnt_r > CNT_W'(1) && top_digit == 4'd0) begin
          buf_nxt = buf_r << 4;
          cnt_nxt = cnt_r - 1'b1;
        end else if (neg_r) begin
          state_nxt = itoa_pkg::ST_SIGN;
        end else begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end

      itoa_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = itoa_pkg::ST_EMIT;
        end
      end

      itoa_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::glyph(top_digit);
          out_last_nxt  = (cnt_r == CNT_W'(1));
          buf_nxt       = buf_r << 4;
          cnt_nxt       = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = itoa_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
